// ----- rtl/core/wfac_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package wfac_pkg;

  // payload size field and derived datapath widths
  localparam int SIZE_BITS_WIDTH = 20;
  localparam int NUM_W = SIZE_BITS_WIDTH + 2;  // dividend: bits*4 or bits+22
  localparam int DIV_W = 10;                   // divisor: rate << 0..2
  localparam int RATE_W = 8;
  localparam int US_W = 24;
  localparam int OVH_W = 8;

  typedef enum logic [1:0] {
    MOD_OFDM  = 2'd0,
    MOD_ERP   = 2'd1,
    MOD_DSSS  = 2'd2,
    MOD_UNSUP = 2'd3
  } mod_class_t;

  typedef enum logic [1:0] {
    BW_20    = 2'd0,
    BW_10    = 2'd1,
    BW_5     = 2'd2,
    BW_OTHER = 2'd3
  } bw_code_t;

  // one request in flight through the divider chain
  typedef struct packed {
    logic              err;
    logic [1:0]        cls;
    logic [1:0]        sym_sh;  // log2(symbol_us / 4)
    logic [OVH_W-1:0]  ovh;
    logic [DIV_W-1:0]  div;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  quo;
    logic [DIV_W-1:0]  rem;
  } wfac_work_t;

endpackage
`default_nettype wire

// ----- rtl/core/wfac_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface wfac_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             mod_class;
  logic [1:0]                             bandwidth_code;
  logic [wfac_pkg::RATE_W-1:0]            rate_units;
  logic                                   short_preamble;
  logic [wfac_pkg::SIZE_BITS_WIDTH-1:0]   payload_bits;

  modport source (output valid, mod_class, bandwidth_code, rate_units, short_preamble,
                  payload_bits, input ready);
  modport sink (input valid, mod_class, bandwidth_code, rate_units, short_preamble,
                payload_bits, output ready);
endinterface

interface wfac_out_if;
  logic                          valid;
  logic                          ready;
  logic [wfac_pkg::US_W-1:0]     total_us;
  logic [wfac_pkg::OVH_W-1:0]    overhead_us;
  logic [wfac_pkg::US_W-1:0]     payload_us;
  logic                          error_flag;

  modport source (output valid, total_us, overhead_us, payload_us, error_flag, input ready);
  modport sink (input valid, total_us, overhead_us, payload_us, error_flag, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/wfac_prep.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wfac_prep (
  input  wire logic [1:0]                           mod_class,
  input  wire logic [1:0]                           bandwidth_code,
  input  wire logic [wfac_pkg::RATE_W-1:0]          rate_units,
  input  wire logic                                 short_preamble,
  input  wire logic [wfac_pkg::SIZE_BITS_WIDTH-1:0] payload_bits,
  output wfac_pkg::wfac_work_t                      work
);
  import wfac_pkg::*;

  logic [1:0] sh;

  always_comb begin
    case (bandwidth_code)
      BW_10:   sh = 2'd1;
      BW_5:    sh = 2'd2;
      default: sh = 2'd0;
    endcase
  end

  always_comb begin
    work        = '0;
    work.cls    = mod_class;
    work.sym_sh = sh;
    work.err    = (mod_class == MOD_UNSUP) || (rate_units == '0);
    if (mod_class == MOD_DSSS) begin
      // ceil(bits*4 / rate)
      work.num = {payload_bits, 2'b00};
      work.div = DIV_W'(rate_units);
      work.ovh = short_preamble ? OVH_W'(96) : OVH_W'(192);
    end else begin
      // ceil((bits+22)*4 / (rate*sym_us)) == ceil((bits+22) / (rate << sh))
      work.num = NUM_W'(payload_bits) + NUM_W'(22);
      work.div = DIV_W'(rate_units) << sh;
      work.ovh = (mod_class == MOD_ERP) ? OVH_W'(20) : (OVH_W'(20) << sh);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/wfac_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wfac_div_cell (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 up_valid,
  input  wfac_pkg::wfac_work_t      up_data,
  output logic                      up_ready,
  output logic                      dn_valid,
  output wfac_pkg::wfac_work_t      dn_data,
  input  wire logic                 dn_ready
);
  import wfac_pkg::*;

  logic              valid_r;
  wfac_work_t        data_r;
  wfac_work_t        data_nxt;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              ge;

  // one restoring step: bring down the next dividend bit
  assign trial = {up_data.rem, up_data.num[NUM_W-1]};
  assign diff  = trial - {1'b0, up_data.div};
  assign ge    = trial >= {1'b0, up_data.div};

  always_comb begin
    data_nxt     = up_data;
    data_nxt.rem = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    data_nxt.num = {up_data.num[NUM_W-2:0], 1'b0};
    data_nxt.quo = {up_data.quo[NUM_W-2:0], ge};
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/wfac_post.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wfac_post (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  input  wfac_pkg::wfac_work_t  up_data,
  output logic                  up_ready,
  wfac_out_if.source            out_ch
);
  import wfac_pkg::*;

  localparam int PAY_W = NUM_W + 6;
  localparam int TOT_W = PAY_W + 1;
  localparam logic [TOT_W-1:0] US_MAX = TOT_W'({US_W{1'b1}});

  logic [NUM_W:0]     nsym;
  logic [PAY_W-1:0]   pay;
  logic [TOT_W-1:0]   tot;
  logic [2:0]         us_sh;

  logic               valid_r;
  logic [US_W-1:0]    total_r;
  logic [US_W-1:0]    total_nxt;
  logic [OVH_W-1:0]   ovh_r;
  logic [OVH_W-1:0]   ovh_nxt;
  logic [US_W-1:0]    pay_r;
  logic [US_W-1:0]    pay_nxt;
  logic               err_r;

  // ceiling from quotient and leftover remainder
  assign nsym  = {1'b0, up_data.quo} + (NUM_W+1)'(up_data.rem != '0);
  assign us_sh = {1'b0, up_data.sym_sh} + 3'd2;

  always_comb begin
    if (up_data.cls == MOD_DSSS) begin
      pay = PAY_W'(nsym);
    end else if (up_data.cls == MOD_ERP) begin
      pay = (PAY_W'(nsym) << us_sh) + PAY_W'(6);  // signal extension
    end else begin
      pay = PAY_W'(nsym) << us_sh;
    end
    tot = TOT_W'(pay) + TOT_W'(up_data.ovh);
    if (up_data.err) begin
      total_nxt = '0;
      ovh_nxt   = '0;
      pay_nxt   = '0;
    end else begin
      total_nxt = (tot > US_MAX) ? US_W'(US_MAX) : tot[US_W-1:0];
      ovh_nxt   = up_data.ovh;
      pay_nxt   = (TOT_W'(pay) > US_MAX) ? US_W'(US_MAX) : pay[US_W-1:0];
    end
  end

  assign up_ready = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      total_r <= total_nxt;
      ovh_r   <= ovh_nxt;
      pay_r   <= pay_nxt;
      err_r   <= up_data.err;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.total_us    = total_r;
  assign out_ch.overhead_us = ovh_r;
  assign out_ch.payload_us  = pay_r;
  assign out_ch.error_flag  = err_r;

endmodule
`default_nettype wire

// ----- rtl/core/wlan_frame_airtime_calc_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// 802.11 frame airtime calculator. Each request describes one frame (class, bandwidth,
// rate in 250 kb/s units, preamble, payload bits) and yields one result: overhead,
// payload and total airtime in whole microseconds, or the error flag with zero times
// for an unsupported class or a zero rate. Fully pipelined: one request per cycle
// while the output does not stall. A request passes the row of NUM_W restoring-division
// cells, one quotient bit each, and then the output register.
// Each cell stalls only when it is full and the next one cannot take its contents,
// so bubbles close up under back-pressure and requests keep entering while a
// finished result waits at the output.
module wlan_frame_airtime_calc_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  wfac_in_if.sink     in_ch,
  wfac_out_if.source  out_ch
);
  import wfac_pkg::*;

  // stage k is the input of cell k; stage NUM_W feeds the output register
  logic        stage_valid [0:NUM_W];
  logic        stage_ready [0:NUM_W];
  wfac_work_t  stage_data  [0:NUM_W];

  // decode: dividend, divisor, overhead and symbol shift per class
  wfac_prep u_prep (
    .mod_class      (in_ch.mod_class),
    .bandwidth_code (in_ch.bandwidth_code),
    .rate_units     (in_ch.rate_units),
    .short_preamble (in_ch.short_preamble),
    .payload_bits   (in_ch.payload_bits),
    .work           (stage_data[0])
  );

  assign stage_valid[0] = in_ch.valid;
  assign in_ch.ready    = stage_ready[0];

  // divider chain, MSB of the quotient first
  for (genvar k = 0; k < NUM_W; k++) begin : g_cell
    wfac_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stage_valid[k]),
      .up_data  (stage_data[k]),
      .up_ready (stage_ready[k]),
      .dn_valid (stage_valid[k+1]),
      .dn_data  (stage_data[k+1]),
      .dn_ready (stage_ready[k+1])
    );
  end

  // ceiling, symbol scaling, extension, saturation and output register
  wfac_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (stage_valid[NUM_W]),
    .up_data  (stage_data[NUM_W]),
    .up_ready (stage_ready[NUM_W]),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

// ----- rtl/core/wfac_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wfac_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [wfac_pkg::US_W-1:0]    out_total_us,
  input wire logic [wfac_pkg::OVH_W-1:0]   out_overhead_us,
  input wire logic [wfac_pkg::US_W-1:0]    out_payload_us,
  input wire logic                         out_error_flag
);
  import wfac_pkg::*;

  logic [US_W:0] sum_w;
  assign sum_w = (US_W+1)'(out_overhead_us) + (US_W+1)'(out_payload_us);

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_total_us) && $stable(out_payload_us))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_flag |->
      out_total_us == '0 && out_overhead_us == '0 && out_payload_us == '0)
    else $error("error result carries non-zero times");

  a_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_error_flag |->
      (US_W+1)'(out_total_us) == sum_w || out_total_us == {US_W{1'b1}})
    else $error("total is not overhead plus payload");

endmodule

bind wlan_frame_airtime_calc_top wfac_checker u_wfac_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_total_us    (out_ch.total_us),
  .out_overhead_us (out_ch.overhead_us),
  .out_payload_us  (out_ch.payload_us),
  .out_error_flag  (out_ch.error_flag)
);
`default_nettype wire

// ----- bench/airtime_check.sv -----
`timescale 1ns / 1ps
// Watches both channels, predicts each accepted request and compares results in order.
module airtime_check (
  input  logic clk,
  input  logic rst_n,
  wfac_in_if   in_ch,
  wfac_out_if  out_ch,
  input  logic drain_done,
  output int   fail_count,
  output int   pending,
  output int   checked
);
  import wfac_pkg::*;

  typedef struct packed {
    logic [US_W-1:0]  total_us;
    logic [OVH_W-1:0] overhead_us;
    logic [US_W-1:0]  payload_us;
    logic             error_flag;
  } airtime_t;

  airtime_t airtime_due[$];
  int       mismatches = 0;
  int       n_checked = 0;
  bit       drained = 1'b0;

  function automatic logic [US_W-1:0] clip_us(longint unsigned v);
    return (v > 64'hFF_FFFF) ? 24'hFF_FFFF : v[US_W-1:0];
  endfunction

  // exact integer ceilings throughout
  function automatic airtime_t calc_airtime(mod_class_t cls, bw_code_t bw,
                                            logic [RATE_W-1:0] rate_in, logic short_pre,
                                            logic [SIZE_BITS_WIDTH-1:0] bits_in);
    longint unsigned sym_us, n_sym, pay, ovh, rate, bits, den;
    airtime_t r;
    rate = rate_in;
    bits = bits_in;
    sym_us = (bw == BW_10) ? 8 : (bw == BW_5) ? 16 : 4;
    ovh = 0;
    pay = 0;
    r.error_flag = 1'b0;
    if (cls == MOD_UNSUP || rate == 0) begin
      r.error_flag = 1'b1;
    end else if (cls == MOD_DSSS) begin
      ovh = short_pre ? 96 : 192;
      pay = (bits * 4 + rate - 1) / rate;
    end else begin
      den = rate * sym_us;
      n_sym = ((bits + 22) * 4 + den - 1) / den;
      pay = n_sym * sym_us;
      if (cls == MOD_ERP) begin
        pay = pay + 6;   // signal extension
        ovh = 20;        // bandwidth does not touch ERP overhead
      end else begin
        ovh = sym_us * 5;
      end
    end
    r.total_us = clip_us(ovh + pay);
    r.overhead_us = ovh[OVH_W-1:0];
    r.payload_us = clip_us(pay);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch at %0t: %s (got %0d, expected %0d)", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    airtime_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        airtime_due.push_back(calc_airtime(mod_class_t'(in_ch.mod_class),
                                           bw_code_t'(in_ch.bandwidth_code),
                                           in_ch.rate_units, in_ch.short_preamble,
                                           in_ch.payload_bits));
      if (out_ch.valid && out_ch.ready) begin
        if (airtime_due.size() == 0) begin
          report_mismatch("result with no request outstanding", out_ch.total_us, 0);
        end else begin
          want = airtime_due.pop_front();
          if (out_ch.total_us !== want.total_us)
            report_mismatch("total_us", out_ch.total_us, want.total_us);
          if (out_ch.overhead_us !== want.overhead_us)
            report_mismatch("overhead_us", out_ch.overhead_us, want.overhead_us);
          if (out_ch.payload_us !== want.payload_us)
            report_mismatch("payload_us", out_ch.payload_us, want.payload_us);
          if (out_ch.error_flag !== want.error_flag)
            report_mismatch("error_flag", out_ch.error_flag, want.error_flag);
          n_checked++;
        end
      end
      if (drain_done && !drained) begin
        drained = 1'b1;
        if (airtime_due.size() != 0)
          report_mismatch("requests left unanswered", airtime_due.size(), 0);
      end
    end
    fail_count <= mismatches;
    pending <= airtime_due.size();
    checked <= n_checked;
  end

endmodule

// ----- bench/tb_wlan_frame_airtime_calc_top.sv -----
`timescale 1ns / 1ps
// Top of the airtime calculator bench: clock, reset, request stimulus, result-side
// back-pressure and the verdict. All prediction and comparison lives in airtime_check.
module tb_wlan_frame_airtime_calc_top;
  import wfac_pkg::*;

  localparam int PIPE_LAT    = NUM_W + 1;   // divider row plus output register
  localparam int RAND_ITEMS  = 1250;
  localparam int HOLD_CYCLES = 150;         // long receiver hold-off, well past pipe depth
  localparam int HOLD_AT     = 300;         // random request index that triggers it
  localparam int PAUSE_AT    = 700;         // sender waits for a full drain here
  localparam int CALM_FROM   = RAND_ITEMS - 150;
  localparam logic [SIZE_BITS_WIDTH-1:0] BITS_MAX = '1;

  logic clk;
  logic rst_n;
  logic drain_done;
  int   fail_count;
  int   pending;
  int   checked;
  int   class_cnt [4];
  bit   hold_req = 1'b0;  // asks the ready process for one long hold-off
  bit   calm = 1'b0;      // no idling on either side once set

  wfac_in_if  in_ch ();
  wfac_out_if out_ch ();

  wlan_frame_airtime_calc_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  airtime_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .drain_done (drain_done),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one request, optionally after an idle burst, and hold it until taken.
  // valid only drops inside an idle burst, so a back-to-back request keeps it high.
  task automatic send_frame(input mod_class_t cls, input bw_code_t bw,
                            input logic [RATE_W-1:0] rate, input logic short_pre,
                            input logic [SIZE_BITS_WIDTH-1:0] bits);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.mod_class      <= cls;
    in_ch.bandwidth_code <= bw;
    in_ch.rate_units     <= rate;
    in_ch.short_preamble <= short_pre;
    in_ch.payload_bits   <= bits;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    class_cnt[cls]++;
  endtask

  // Result side: random stall bursts, high stretches, and the one long hold-off.
  // The hold-off is counted here so the sender keeps filling the pipe meanwhile.
  initial begin
    int hold_cnt;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin
    int                         c, b, n, k, guard;
    mod_class_t                 cls;
    logic [RATE_W-1:0]          rate;
    logic [SIZE_BITS_WIDTH-1:0] bits;

    // every input known from time zero
    in_ch.valid          <= 1'b0;
    in_ch.mod_class      <= MOD_OFDM;
    in_ch.bandwidth_code <= BW_20;
    in_ch.rate_units     <= '0;
    in_ch.short_preamble <= 1'b0;
    in_ch.payload_bits   <= '0;
    drain_done           <= 1'b0;
    rst_n                <= 1'b0;
    foreach (class_cnt[i]) class_cnt[i] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: slowest rate with the largest payload on every supported class and
    // bandwidth code (bandwidth three folds to 20 MHz, DSSS ignores bandwidth),
    // preamble alternating so DSSS sees both headers.
    for (c = 0; c < 3; c++)
      for (b = 0; b < 4; b++)
        send_frame(mod_class_t'(c), bw_code_t'(b), 8'd1, b[0], BITS_MAX);
    // fastest rate, empty payload: single-symbol / zero-time edges; then other sizes
    send_frame(MOD_OFDM, BW_20, 8'd255, 1'b0, '0);
    send_frame(MOD_ERP, BW_5, 8'd255, 1'b1, '0);
    send_frame(MOD_DSSS, BW_OTHER, 8'd255, 1'b1, '0);
    send_frame(MOD_DSSS, BW_20, 8'd255, 1'b0, BITS_MAX);
    send_frame(MOD_OFDM, BW_10, 8'd24, 1'b0, 20'd1000);
    // unsupported class, with a good rate and with zero rate
    send_frame(MOD_UNSUP, BW_20, 8'd22, 1'b1, 20'd12000);
    send_frame(MOD_UNSUP, BW_OTHER, 8'd0, 1'b0, BITS_MAX);
    // zero rate on each supported class
    send_frame(MOD_OFDM, BW_20, 8'd0, 1'b0, 20'd100);
    send_frame(MOD_ERP, BW_10, 8'd0, 1'b1, 20'd100);
    send_frame(MOD_DSSS, BW_5, 8'd0, 1'b1, 20'd100);

    // Random requests. Stateless block, so every request is meaningful; rates and
    // sizes lean towards their extremes now and then, but every bit gets exercised.
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n == HOLD_AT) hold_req = 1'b1;
      if (n == PAUSE_AT) begin
        // sender pause until every outstanding request has been answered
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      if (n == CALM_FROM) calm = 1'b1;

      k = $urandom_range(0, 9);
      if (k < 3)      cls = MOD_OFDM;
      else if (k < 6) cls = MOD_ERP;
      else if (k < 9) cls = MOD_DSSS;
      else            cls = MOD_UNSUP;

      k = $urandom_range(0, 15);
      if (k == 0)      rate = '0;
      else if (k == 1) rate = 8'd1;
      else if (k == 2) rate = 8'd255;
      else             rate = RATE_W'($urandom_range(1, 255));

      k = $urandom_range(0, 7);
      if (k == 0)      bits = '0;
      else if (k == 1) bits = BITS_MAX;
      else if (k < 5)  bits = SIZE_BITS_WIDTH'($urandom_range(0, 1023));
      else             bits = SIZE_BITS_WIDTH'($urandom_range(0, (1 << SIZE_BITS_WIDTH) - 1));

      send_frame(cls, bw_code_t'($urandom_range(0, 3)), rate, 1'($urandom_range(0, 1)),
                 bits);
    end
    in_ch.valid <= 1'b0;

    // drain, then give a stray late result a chance to show up
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending != 0 && guard < 20000);
    repeat (PIPE_LAT + 8) @(posedge clk);
    drain_done <= 1'b1;
    repeat (3) @(posedge clk);

    $display("Covered %0d requests: %0d OFDM, %0d ERP-OFDM, %0d DSSS, %0d unsupported;",
             class_cnt[0] + class_cnt[1] + class_cnt[2] + class_cnt[3],
             class_cnt[MOD_OFDM], class_cnt[MOD_ERP], class_cnt[MOD_DSSS],
             class_cnt[MOD_UNSUP]);
    $display("%0d results checked, with a %0d-cycle receiver hold-off and one full drain.",
             checked, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("PASS wlan_frame_airtime_calc_top");
    end else begin
      $display("FAIL wlan_frame_airtime_calc_top");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run
  initial begin
    #4_000_000;
    $display("FAIL wlan_frame_airtime_calc_top");
    $finish;
  end

endmodule
